@@ hdl/lid_pkg.sv @@
// Shared widths and default parameters for the line intersection distance block.
package lid_pkg;

    localparam int NORM_W  = 16;
    localparam int OFFS_W  = 32;
    localparam int THICK_W = 16;
    localparam int CD_W    = OFFS_W + 2;
    localparam int DET_W   = 2 * NORM_W + 1;
    localparam int NUM_W   = CD_W + NORM_W + 1;

    localparam int FRAC_BITS_DEF  = 8;
    localparam int COORD_BITS_DEF = 40;

endpackage

@@ hdl/lid_mac.sv @@
// Bit-serial difference of two products, a1*b1 - a2*b2, multiplier bits taken MSB first.
module lid_mac #(
    parameter int AW = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [AW-1:0] a1,
    input  logic signed [AW-1:0] a2,
    input  logic signed [lid_pkg::NORM_W-1:0] b1,
    input  logic signed [lid_pkg::NORM_W-1:0] b2,
    output logic                 done,
    output logic signed [AW+lid_pkg::NORM_W:0] result
);

    localparam int BW = lid_pkg::NORM_W;
    localparam int RW = AW + BW + 1;
    localparam int CW = $clog2(BW + 1);

    logic signed [AW-1:0] a1_reg, a2_reg;
    logic [BW-1:0]        b1_reg, b2_reg;
    logic signed [RW-1:0] acc_reg, acc_next;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg, done_reg;
    logic signed [AW:0]   term, step;

    always_comb begin
        term = (b1_reg[BW-1] ? {a1_reg[AW-1], a1_reg} : '0)
             - (b2_reg[BW-1] ? {a2_reg[AW-1], a2_reg} : '0);
        step = (cnt_reg == '0) ? -term : term;
        acc_next = (acc_reg <<< 1) + {{(RW-AW-1){step[AW]}}, step};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a1_reg   <= a1;
                a2_reg   <= a2;
                b1_reg   <= b1;
                b2_reg   <= b2;
                acc_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                acc_reg <= acc_next;
                b1_reg  <= b1_reg << 1;
                b2_reg  <= b2_reg << 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(BW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

@@ hdl/lid_div.sv @@
// Restoring divider: num / (2*det) in fixed point, rounded and saturated, one bit per cycle.
module lid_div #(
    parameter int NW         = lid_pkg::NUM_W,
    parameter int DW         = lid_pkg::DET_W,
    parameter int FRAC_BITS  = lid_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = lid_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [NW-1:0]         num,
    input  logic signed [DW-1:0]         det,
    output logic                         done,
    output logic signed [COORD_BITS-1:0] quot
);

    localparam int C    = COORD_BITS;
    localparam int NQ_W = NW + FRAC_BITS + 2;
    localparam int RM_W = DW + 2;
    localparam int CW   = $clog2(NQ_W + 1);

    logic [NW-1:0]   n_mag;
    logic [DW-1:0]   d_mag;
    logic [NQ_W-1:0] nsh_reg;
    logic [RM_W-1:0] d_reg, rem_reg, rem_next;
    logic [RM_W:0]   rem_sh, rem_diff;
    logic            ge;
    logic [C-1:0]    q_reg;
    logic            ovf_reg, neg_reg, busy_reg, done_reg, big;
    logic [CW-1:0]   cnt_reg;

    always_comb begin
        n_mag    = num[NW-1] ? NW'(-num) : NW'(num);
        d_mag    = det[DW-1] ? DW'(-det) : DW'(det);
        rem_sh   = {rem_reg, nsh_reg[NQ_W-1]};
        rem_diff = rem_sh - {1'b0, d_reg};
        ge       = rem_sh >= {1'b0, d_reg};
        rem_next = ge ? rem_diff[RM_W-1:0] : rem_sh[RM_W-1:0];
        big      = ovf_reg | q_reg[C-1];
        if (big) begin
            quot = neg_reg ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
        end else begin
            quot = neg_reg ? -$signed(q_reg) : $signed(q_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                nsh_reg  <= NQ_W'({n_mag, {(FRAC_BITS+1){1'b0}}}) + NQ_W'({d_mag, 1'b0});
                d_reg    <= {d_mag, 2'b00};
                rem_reg  <= '0;
                q_reg    <= '0;
                ovf_reg  <= 1'b0;
                neg_reg  <= num[NW-1] ^ det[DW-1];
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                nsh_reg <= nsh_reg << 1;
                q_reg   <= {q_reg[C-2:0], ge};
                ovf_reg <= ovf_reg | q_reg[C-1];
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NQ_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;

endmodule

@@ hdl/lid_dist.sv @@
// Distance unit: serial sum of squares, then bit-serial integer square root.
module lid_dist #(
    parameter int COORD_BITS = lid_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [COORD_BITS-1:0] x,
    input  logic signed [COORD_BITS-1:0] y,
    input  logic signed [COORD_BITS-1:0] prev_x,
    input  logic signed [COORD_BITS-1:0] prev_y,
    output logic                         done,
    output logic [COORD_BITS-1:0]        dist_out
);

    localparam int C  = COORD_BITS;
    localparam int CW = $clog2(C + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SQUARE, ST_ROOT} state_t;

    state_t          state_reg;
    logic signed [C:0] dx_full, dy_full;
    logic [C-1:0]    dxm, dym;
    logic [C-1:0]    dx_reg, dy_reg, dxs_reg, dys_reg;
    logic [C:0]      hi_reg;
    logic [C-1:0]    lo_reg;
    logic [C+1:0]    sum;
    logic [2*C-1:0]  rad_reg;
    logic [C:0]      rem_reg, rem_next;
    logic [C+2:0]    rem_sh, rem_diff;
    logic [C+1:0]    trial;
    logic [C-1:0]    root_reg;
    logic            ge, sat_reg, done_reg;
    logic [CW-1:0]   cnt_reg;

    always_comb begin
        dx_full  = {x[C-1], x} - {prev_x[C-1], prev_x};
        dy_full  = {y[C-1], y} - {prev_y[C-1], prev_y};
        dxm      = dx_full[C] ? C'(-dx_full) : dx_full[C-1:0];
        dym      = dy_full[C] ? C'(-dy_full) : dy_full[C-1:0];
        sum      = {1'b0, hi_reg} + (dxs_reg[0] ? {2'b00, dx_reg} : '0)
                 + (dys_reg[0] ? {2'b00, dy_reg} : '0);
        rem_sh   = {rem_reg, rad_reg[2*C-1:2*C-2]};
        trial    = {root_reg, 2'b01};
        rem_diff = rem_sh - {1'b0, trial};
        ge       = rem_sh >= {1'b0, trial};
        rem_next = ge ? rem_diff[C:0] : rem_sh[C:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        dx_reg    <= dxm;
                        dy_reg    <= dym;
                        dxs_reg   <= dxm;
                        dys_reg   <= dym;
                        hi_reg    <= '0;
                        lo_reg    <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE: begin
                    hi_reg  <= sum[C+1:1];
                    lo_reg  <= {sum[0], lo_reg[C-1:1]};
                    dxs_reg <= dxs_reg >> 1;
                    dys_reg <= dys_reg >> 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(C - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (cnt_reg == '0) begin
                        sat_reg  <= hi_reg[C];
                        rad_reg  <= {hi_reg[C-1:0], lo_reg};
                        rem_reg  <= '0;
                        root_reg <= '0;
                        cnt_reg  <= cnt_reg + 1'b1;
                    end else begin
                        rem_reg  <= rem_next;
                        root_reg <= {root_reg[C-2:0], ge};
                        rad_reg  <= rad_reg << 2;
                        cnt_reg  <= cnt_reg + 1'b1;
                        if (cnt_reg == CW'(C)) begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign done     = done_reg;
    assign dist_out = sat_reg ? {C{1'b1}} : root_reg;

endmodule

@@ hdl/line_intersection_distance.sv @@
// Top level: intersection of two thick lines and distance to the previous point.
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | two lines (normal, offset, thickness), row_start
//  m_      | out       | m_valid / m_ready | point_x/y, point_valid, distance, distance_valid
//
// One item at a time. Parallel lines (det zero) end after the products, and an item with no
// previous point skips the distance unit. The work is 16 product steps, NUM_W+FRAC_BITS+2
// = 61 divider steps for both coordinates side by side, then COORD_BITS square steps, a root
// load and COORD_BITS root steps, with a registered start handed from each unit to the next.
// Reset (aresetn low, synchronous) forgets the previous point and empties the block.
// A result waits in the output registers until taken; s_ready stays low meanwhile.
module line_intersection_distance #(
    parameter int FRAC_BITS  = lid_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = lid_pkg::COORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [lid_pkg::NORM_W-1:0]   s_base_normal_x,
    input  logic signed [lid_pkg::NORM_W-1:0]   s_base_normal_y,
    input  logic signed [lid_pkg::OFFS_W-1:0]   s_base_offset,
    input  logic [lid_pkg::THICK_W-1:0]         s_base_thickness,
    input  logic signed [lid_pkg::NORM_W-1:0]   s_cross_normal_x,
    input  logic signed [lid_pkg::NORM_W-1:0]   s_cross_normal_y,
    input  logic signed [lid_pkg::OFFS_W-1:0]   s_cross_offset,
    input  logic [lid_pkg::THICK_W-1:0]         s_cross_thickness,
    input  logic                                s_row_start,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [COORD_BITS-1:0]        m_point_x,
    output logic signed [COORD_BITS-1:0]        m_point_y,
    output logic                                m_point_valid,
    output logic [COORD_BITS-1:0]               m_distance,
    output logic                                m_distance_valid
);

    localparam int NW  = lid_pkg::NORM_W;
    localparam int CDW = lid_pkg::CD_W;
    localparam int DTW = lid_pkg::DET_W;
    localparam int NMW = lid_pkg::NUM_W;
    localparam int C   = COORD_BITS;

    typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DIST, ST_OUT} state_t;

    state_t state_reg;
    logic signed [NW-1:0]  ad_reg, bd_reg, an_reg, bn_reg;
    logic signed [CDW-1:0] cd_reg, cn_reg;
    logic                  mul_start_reg, div_start_reg, dist_start_reg;
    logic                  det_done, nx_done, ny_done, dx_done, dy_done, dist_done;
    logic signed [DTW-1:0] det;
    logic signed [NMW-1:0] num_x, num_y;
    logic signed [C-1:0]   px, py;
    logic [C-1:0]          dist_val;
    logic signed [C-1:0]   prev_x_reg, prev_y_reg;
    logic                  prev_present_reg;
    logic signed [C-1:0]   point_x_reg, point_y_reg;
    logic                  point_valid_reg, distance_valid_reg;
    logic [C-1:0]          distance_reg;

    lid_mac #(.AW(NW)) u_det (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start_reg),
        .a1(ad_reg), .a2(an_reg), .b1(bn_reg), .b2(bd_reg),
        .done(det_done), .result(det)
    );

    lid_mac #(.AW(CDW)) u_num_x (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start_reg),
        .a1(cd_reg), .a2(cn_reg), .b1(bn_reg), .b2(bd_reg),
        .done(nx_done), .result(num_x)
    );

    lid_mac #(.AW(CDW)) u_num_y (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start_reg),
        .a1(cn_reg), .a2(cd_reg), .b1(ad_reg), .b2(an_reg),
        .done(ny_done), .result(num_y)
    );

    lid_div #(.NW(NMW), .DW(DTW), .FRAC_BITS(FRAC_BITS), .COORD_BITS(C)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg),
        .num(num_x), .det(det), .done(dx_done), .quot(px)
    );

    lid_div #(.NW(NMW), .DW(DTW), .FRAC_BITS(FRAC_BITS), .COORD_BITS(C)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg),
        .num(num_y), .det(det), .done(dy_done), .quot(py)
    );

    lid_dist #(.COORD_BITS(C)) u_dist (
        .aclk(aclk), .aresetn(aresetn), .start(dist_start_reg),
        .x(point_x_reg), .y(point_y_reg), .prev_x(prev_x_reg), .prev_y(prev_y_reg),
        .done(dist_done), .dist_out(dist_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            mul_start_reg    <= 1'b0;
            div_start_reg    <= 1'b0;
            dist_start_reg   <= 1'b0;
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
            prev_present_reg <= 1'b0;
        end else begin
            mul_start_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            dist_start_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        ad_reg <= s_base_normal_x;
                        bd_reg <= s_base_normal_y;
                        an_reg <= s_cross_normal_x;
                        bn_reg <= s_cross_normal_y;
                        cd_reg <= {s_base_offset[lid_pkg::OFFS_W-1], s_base_offset, 1'b0}
                                + CDW'(s_base_thickness);
                        cn_reg <= {s_cross_offset[lid_pkg::OFFS_W-1], s_cross_offset, 1'b0}
                                + CDW'(s_cross_thickness);
                        if (s_row_start) begin
                            prev_present_reg <= 1'b0;
                        end
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (det_done && nx_done && ny_done) begin
                        if (det == '0) begin
                            point_x_reg        <= '0;
                            point_y_reg        <= '0;
                            point_valid_reg    <= 1'b0;
                            distance_reg       <= '0;
                            distance_valid_reg <= 1'b0;
                            prev_present_reg   <= 1'b0;
                            state_reg          <= ST_OUT;
                        end else begin
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (dx_done && dy_done) begin
                        point_x_reg     <= px;
                        point_y_reg     <= py;
                        point_valid_reg <= 1'b1;
                        if (prev_present_reg) begin
                            dist_start_reg <= 1'b1;
                            state_reg      <= ST_DIST;
                        end else begin
                            distance_reg       <= '0;
                            distance_valid_reg <= 1'b0;
                            prev_x_reg         <= px;
                            prev_y_reg         <= py;
                            prev_present_reg   <= 1'b1;
                            state_reg          <= ST_OUT;
                        end
                    end
                end
                ST_DIST: begin
                    if (dist_done) begin
                        distance_reg       <= dist_val;
                        distance_valid_reg <= 1'b1;
                        prev_x_reg         <= point_x_reg;
                        prev_y_reg         <= point_y_reg;
                        prev_present_reg   <= 1'b1;
                        state_reg          <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = (state_reg == ST_OUT);
    assign m_point_x        = point_x_reg;
    assign m_point_y        = point_y_reg;
    assign m_point_valid    = point_valid_reg;
    assign m_distance       = distance_reg;
    assign m_distance_valid = distance_valid_reg;

endmodule
